// ===== rtl/isr_pkg.sv =====
// ----------------------------------------------------------------------------
// isr_pkg
// Types, constants and small tables shared by the stereo reverb step block.
// ----------------------------------------------------------------------------
`default_nettype none
package isr_pkg;

    localparam int unsigned DIV_W   = 32;   // ring position before reduction
    localparam int unsigned MOD_W   = 23;   // work-area size, up to 2^22
    localparam int unsigned A_W     = 22;   // halfword address width
    localparam int unsigned N_ADDR  = 14;
    localparam int unsigned N_RD    = 10;
    localparam int unsigned N_OPS   = 13;
    localparam int unsigned N_WR    = 4;
    localparam logic [21:0] A22_MASK = 22'h3f_ffff;
    localparam logic [21:0] LOW_FILL = 22'h00_ffff;
    localparam int unsigned Q_SHIFT = 15;

    // configuration register indexes
    localparam logic [2:0] REG_AREA_START = 3'd0;
    localparam logic [2:0] REG_AREA_END   = 3'd1;
    localparam logic [2:0] REG_EFFECTS    = 3'd2;
    localparam logic [2:0] REG_IRQ_EN_A   = 3'd3;
    localparam logic [2:0] REG_IRQ_ADR_A  = 3'd4;
    localparam logic [2:0] REG_IRQ_EN_B   = 3'd5;
    localparam logic [2:0] REG_IRQ_ADR_B  = 3'd6;

    // input kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_PARAM  = 1'b1;

    // preset word indexes
    localparam logic [4:0] P_APF1_SIZE = 5'd2;
    localparam logic [4:0] P_APF2_SIZE = 5'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OFS,
        ST_ADDR,
        ST_MODW,
        ST_RD,
        ST_RDW,
        ST_MUL,
        ST_ADD,
        ST_WR,
        ST_DONE
    } t_state;

    // preset word giving the ring offset of address slot k
    function automatic logic [4:0] f_ofs_idx(input logic [3:0] k, input logic r);
        logic [4:0] idx;
        case (k)
            4'd0:    idx = 5'd18 + {4'd0, r};
            4'd1:    idx = 5'd22 + {4'd0, r};
            4'd2:    idx = 5'd22 + {4'd0, r};
            4'd3:    idx = 5'd21 - {4'd0, r};
            4'd4:    idx = 5'd24 + {4'd0, r};
            4'd5:    idx = 5'd24 + {4'd0, r};
            4'd6:    idx = 5'd10 + {4'd0, r};
            4'd7:    idx = 5'd12 + {4'd0, r};
            4'd8:    idx = 5'd14 + {4'd0, r};
            4'd9:    idx = 5'd16 + {4'd0, r};
            4'd10:   idx = 5'd28 + {4'd0, r};
            4'd11:   idx = 5'd28 + {4'd0, r};
            4'd12:   idx = 5'd30 + {4'd0, r};
            4'd13:   idx = 5'd30 + {4'd0, r};
            default: idx = 5'd0;
        endcase
        return idx;
    endfunction

    // address slots read from the work area, in order
    function automatic logic [3:0] f_rd_slot(input logic [3:0] i);
        logic [3:0] s;
        case (i)
            4'd0:    s = 4'd0;
            4'd1:    s = 4'd2;
            4'd2:    s = 4'd3;
            4'd3:    s = 4'd5;
            4'd4:    s = 4'd6;
            4'd5:    s = 4'd7;
            4'd6:    s = 4'd8;
            4'd7:    s = 4'd9;
            4'd8:    s = 4'd10;
            4'd9:    s = 4'd12;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // address slots written back: same, cross, apf1, apf2
    function automatic logic [3:0] f_wr_slot(input logic [1:0] i);
        logic [3:0] s;
        case (i)
            2'd0:    s = 4'd1;
            2'd1:    s = 4'd4;
            2'd2:    s = 4'd11;
            default: s = 4'd13;
        endcase
        return s;
    endfunction

    // preset word used as coefficient by each mac step
    function automatic logic [4:0] f_op_pidx(input logic [3:0] op, input logic r);
        logic [4:0] idx;
        case (op)
            4'd0:    idx = {4'd0, r};
            4'd1:    idx = 5'd27;
            4'd2:    idx = 5'd26;
            4'd3:    idx = 5'd27;
            4'd4:    idx = 5'd26;
            4'd5:    idx = 5'd6;
            4'd6:    idx = 5'd7;
            4'd7:    idx = 5'd8;
            4'd8:    idx = 5'd9;
            4'd9:    idx = 5'd4;
            4'd10:   idx = 5'd4;
            4'd11:   idx = 5'd5;
            4'd12:   idx = 5'd5;
            default: idx = 5'd0;
        endcase
        return idx;
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [31:0] v);
        logic signed [15:0] s;
        if (v > 32'sd32767) begin
            s = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            s = 16'sh8000;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/isr_mod.sv =====
// ----------------------------------------------------------------------------
// isr_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module isr_mod
    import isr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [MOD_W-1:0] i_modulus,
    output logic                  o_done,
    output logic [A_W-1:0]        o_rem
);

    logic [DIV_W-1:0] r_div;
    logic [MOD_W:0]   r_rem;
    logic [MOD_W:0]   r_mod;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MOD_W:0]   w_try;
    logic [MOD_W:0]   w_next;

    assign w_try  = {r_rem[MOD_W-1:0], r_div[DIV_W-1]};
    assign w_next = (w_try >= r_mod) ? (w_try - r_mod) : w_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_div  <= i_dividend;
                r_rem  <= '0;
                r_mod  <= {1'b0, i_modulus};
            end else if (r_busy) begin
                r_rem <= w_next;
                r_div <= {r_div[DIV_W-2:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[A_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/isr_mac.sv =====
// ----------------------------------------------------------------------------
// isr_mac
// Shared q15 multiply unit: registered product, then c1 +/- (a*b >>> 15) - c2.
// ----------------------------------------------------------------------------
`default_nettype none
module isr_mac
    import isr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_mul_en,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic signed [31:0] i_c1,
    input  wire logic signed [31:0] i_c2,
    input  wire logic               i_neg,
    output logic signed [31:0]      o_res
);

    logic signed [63:0] r_prod;
    logic signed [31:0] r_c1;
    logic signed [31:0] r_c2;
    logic               r_neg;
    logic signed [31:0] w_q;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_a * i_b;
            r_c1   <= i_c1;
            r_c2   <= i_c2;
            r_neg  <= i_neg;
        end
    end

    // arithmetic shift, wrapped to 32 bits
    assign w_q   = r_prod[Q_SHIFT+31:Q_SHIFT];
    assign o_res = r_neg ? (r_c1 - w_q - r_c2) : (r_c1 + w_q - r_c2);

endmodule
`default_nettype wire

// ===== rtl/interleaved_stereo_reverb_step_top.sv =====
// ----------------------------------------------------------------------------
// interleaved_stereo_reverb_step_top
// Stereo reverb step over a ring work area, one channel per sample transfer.
// ----------------------------------------------------------------------------
// After reset the block clears the 2^ADDR_BITS-word work area, one word a cycle,
// and accepts no item meanwhile (configuration writes still work). A parameter
// transfer leaves the block idle. A sample transfer keeps the block busy after it
// is taken: each of the 14 ring addresses goes through the shared bit-serial
// remainder unit, then 10 single-port reads (read and wait states), 13 steps of
// the shared multiplier (multiply and add states), 4 write-back steps (written
// only with effects on) and a done state; with an empty work area the block goes
// straight to done. The next item is taken while a result waits on the output.
`default_nettype none
module interleaved_stereo_reverb_step_top
    import isr_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,  // sample_in[15:0], param_index[20:16],
                                         // param_value[52:21], zero pad
    input  wire logic        i_s_tuser,  // kind
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // wet_sample[15:0], irq_hit_a[16],
                                         // irq_hit_b[17], zero pad
    output logic             o_m_tuser   // is_right
);

    localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

    t_state r_state, n_state;

    // configuration
    logic [A_W-1:0] r_start, r_end, r_irq_a, r_irq_b;
    logic           r_effects, r_irq_en_a, r_irq_en_b;

    logic [31:0]     r_pre [32];
    logic [31:0]     r_cnt;
    logic signed [15:0] r_smp;
    logic [3:0]      r_k;
    logic [31:0]     r_osub;
    logic [ADDR_BITS-1:0] r_ad [N_ADDR];
    logic signed [15:0]   r_md [N_ADDR];
    logic [15:0]     r_rdata;
    logic [ADDR_BITS-1:0] r_clr;
    logic            r_hit_a, r_hit_b, r_empty;
    logic signed [31:0] r_x, r_t, r_same, r_diff, r_acc, r_apf1, r_apf2;
    logic            r_ovalid;
    logic [15:0]     r_owet;
    logic            r_ohit_a, r_ohit_b, r_oright;
    logic [15:0]     r_mem [MEM_DEPTH];

    logic            w_cfg_wr, w_s_acc, w_load, w_mem_we;
    logic [4:0]      w_pidx;
    logic [31:0]     w_pw;
    logic [MOD_W-1:0] w_mod;
    logic [21:0]     w_end_f;
    logic            w_mod_start, w_mod_done;
    logic [A_W-1:0]  w_rem;
    logic [MOD_W-1:0] w_asum;
    logic [ADDR_BITS-1:0] w_ad, w_maddr;
    logic [15:0]     w_wdata;
    logic signed [31:0] w_b, w_c1, w_c2, w_res, w_sel_wr;
    logic            w_neg;
    logic [3:0]      w_slot;
    logic            w_rng_a, w_rng_b;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_s_acc  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_load   = (r_state == ST_DONE) && (!r_ovalid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_end      <= '0;
            r_effects  <= 1'b0;
            r_irq_en_a <= 1'b0;
            r_irq_a    <= '0;
            r_irq_en_b <= 1'b0;
            r_irq_b    <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_AREA_START: r_start    <= pwdata[A_W-1:0];
                REG_AREA_END:   r_end      <= pwdata[A_W-1:0];
                REG_EFFECTS:    r_effects  <= pwdata[0];
                REG_IRQ_EN_A:   r_irq_en_a <= pwdata[0];
                REG_IRQ_ADR_A:  r_irq_a    <= pwdata[A_W-1:0];
                REG_IRQ_EN_B:   r_irq_en_b <= pwdata[0];
                REG_IRQ_ADR_B:  r_irq_b    <= pwdata[A_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_AREA_START: prdata = 32'(r_start);
            REG_AREA_END:   prdata = 32'(r_end);
            REG_EFFECTS:    prdata = 32'(r_effects);
            REG_IRQ_EN_A:   prdata = 32'(r_irq_en_a);
            REG_IRQ_ADR_A:  prdata = 32'(r_irq_a);
            REG_IRQ_EN_B:   prdata = 32'(r_irq_en_b);
            REG_IRQ_ADR_B:  prdata = 32'(r_irq_b);
            default:        prdata = '0;
        endcase
    end

    // ring size: (end | 0xffff) - start + 1
    assign w_end_f = (r_end & A22_MASK) | LOW_FILL;
    assign w_mod   = {1'b0, w_end_f} - {1'b0, r_start} + 23'd1;

    always_comb begin
        case (r_state)
            ST_OFS:  w_pidx = (r_k == 4'd10) ? P_APF1_SIZE : P_APF2_SIZE;
            ST_ADDR: w_pidx = f_ofs_idx(r_k, r_cnt[0]);
            ST_MUL:  w_pidx = f_op_pidx(r_k, r_cnt[0]);
            default: w_pidx = '0;
        endcase
    end
    assign w_pw = r_pre[w_pidx];

    assign w_mod_start = (r_state == ST_ADDR);

    isr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend ({1'b0, r_cnt[31:1]} + w_pw - r_osub),
        .i_modulus  (w_mod),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    assign w_asum  = {1'b0, w_rem} + {1'b0, r_start};
    assign w_ad    = w_asum[ADDR_BITS-1:0];
    assign w_rng_a = (r_irq_a >= r_start) && (r_irq_a <= r_end);
    assign w_rng_b = (r_irq_b >= r_start) && (r_irq_b <= r_end);

    // mac operand selection per step
    always_comb begin
        w_b = '0; w_c1 = '0; w_c2 = '0; w_neg = 1'b0;
        case (r_k)
            4'd0:  w_b = 32'(r_smp);
            4'd1:  begin w_b = 32'(r_md[0]); w_c1 = r_x; w_c2 = 32'(r_md[2]); end
            4'd2:  begin w_b = r_t; w_c1 = 32'(r_md[2]); end
            4'd3:  begin w_b = 32'(r_md[3]); w_c1 = r_x; w_c2 = 32'(r_md[5]); end
            4'd4:  begin w_b = r_t; w_c1 = 32'(r_md[5]); end
            4'd5:  begin w_b = 32'(r_md[6]); w_c1 = r_acc; end
            4'd6:  begin w_b = 32'(r_md[7]); w_c1 = r_acc; end
            4'd7:  begin w_b = 32'(r_md[8]); w_c1 = r_acc; end
            4'd8:  begin w_b = 32'(r_md[9]); w_c1 = r_acc; end
            4'd9:  begin w_b = 32'(r_md[10]); w_c1 = r_acc; w_neg = 1'b1; end
            4'd10: begin w_b = r_apf1; w_c1 = 32'(r_md[10]); end
            4'd11: begin w_b = 32'(r_md[12]); w_c1 = r_acc; w_neg = 1'b1; end
            4'd12: begin w_b = r_apf2; w_c1 = 32'(r_md[12]); end
            default: ;
        endcase
    end

    isr_mac u_mac (
        .i_clk    (i_clk),
        .i_mul_en (r_state == ST_MUL),
        .i_a      (w_pw),
        .i_b      (w_b),
        .i_c1     (w_c1),
        .i_c2     (w_c2),
        .i_neg    (w_neg),
        .o_res    (w_res)
    );

    // memory port
    always_comb begin
        case (r_k[1:0])
            2'd0:    w_sel_wr = r_same;
            2'd1:    w_sel_wr = r_diff;
            2'd2:    w_sel_wr = r_apf1;
            default: w_sel_wr = r_apf2;
        endcase
    end
    assign w_slot   = (r_state == ST_WR) ? f_wr_slot(r_k[1:0]) : f_rd_slot(r_k);
    assign w_maddr  = (r_state == ST_CLEAR) ? r_clr : r_ad[w_slot];
    assign w_wdata  = (r_state == ST_CLEAR) ? 16'h0 : f_sat16(w_sel_wr);
    assign w_mem_we = (r_state == ST_CLEAR) || ((r_state == ST_WR) && r_effects);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_maddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_maddr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_s_acc && i_s_tuser == KIND_SAMPLE) begin
                    n_state = (r_start >= r_end) ? ST_DONE : ST_OFS;
                end
            end
            ST_OFS:  n_state = ST_ADDR;
            ST_ADDR: n_state = ST_MODW;
            ST_MODW: begin
                if (w_mod_done) n_state = (r_k == 4'(N_ADDR - 1)) ? ST_RD : ST_OFS;
            end
            ST_RD:   n_state = ST_RDW;
            ST_RDW:  n_state = (r_k == 4'(N_RD - 1)) ? ST_MUL : ST_RD;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = (r_k == 4'(N_OPS - 1)) ? ST_WR : ST_MUL;
            ST_WR:   if (r_k == 4'(N_WR - 1)) n_state = ST_DONE;
            ST_DONE: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 32; i++) r_pre[i] <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_IDLE: begin
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_hit_a <= 1'b0;
                    r_hit_b <= 1'b0;
                    r_smp   <= i_s_tdata[15:0];
                    r_empty <= (r_start >= r_end);
                    if (w_s_acc && i_s_tuser == KIND_PARAM) begin
                        r_pre[i_s_tdata[20:16]] <= i_s_tdata[52:21];
                    end
                end
                ST_OFS: begin
                    if (r_k == 4'd10 || r_k == 4'd12) r_osub <= w_pw;
                    else if (r_k == 4'd2 || r_k == 4'd5) r_osub <= 32'd1;
                    else r_osub <= '0;
                end
                ST_MODW: begin
                    if (w_mod_done) begin
                        r_ad[r_k] <= w_ad;
                        if (r_irq_a == A_W'(w_ad)) r_hit_a <= 1'b1;
                        if (r_irq_b == A_W'(w_ad)) r_hit_b <= 1'b1;
                        r_k <= (r_k == 4'(N_ADDR - 1)) ? 4'd0 : r_k + 4'd1;
                    end
                end
                ST_RDW: begin
                    r_md[f_rd_slot(r_k)] <= r_rdata;
                    r_k <= (r_k == 4'(N_RD - 1)) ? 4'd0 : r_k + 4'd1;
                end
                ST_ADD: begin
                    case (r_k)
                        4'd0:         r_x    <= w_res;
                        4'd1, 4'd3:   r_t    <= w_res;
                        4'd2:         r_same <= w_res;
                        4'd4:         r_diff <= w_res;
                        4'd9:         r_apf1 <= w_res;
                        4'd11:        r_apf2 <= w_res;
                        default:      r_acc  <= w_res;
                    endcase
                    r_k <= (r_k == 4'(N_OPS - 1)) ? 4'd0 : r_k + 4'd1;
                end
                ST_WR: r_k <= r_k + 4'd1;
                ST_DONE: begin
                    if (w_load) begin
                        r_oright <= r_cnt[0];
                        r_owet   <= r_empty ? 16'h0 : f_sat16(r_acc);
                        r_ohit_a <= !r_empty && r_hit_a && r_effects && r_irq_en_a && w_rng_a;
                        r_ohit_b <= !r_empty && r_hit_b && r_effects && r_irq_en_b && w_rng_b;
                        r_cnt    <= r_cnt + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_ohit_b, r_ohit_a, r_owet};
    assign o_m_tuser  = r_oright;

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_tready && !o_m_tvalid)
        else $error("item path active during clear");
    a_wr_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == ST_CLEAR) || r_effects)
        else $error("write-back without effects enabled");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_cnt == $past(r_cnt) + 32'd1) && o_m_tvalid)
        else $error("sample counter did not advance with result");
    a_hit_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[16] || o_m_tdata[17])) |-> r_effects)
        else $error("irq hit without effects enabled");

endmodule
`default_nettype wire
